@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module of the section deframer.
// Each macro expands to one labelled concurrent assertion, clocked and reset-gated.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/ssdc_pkg.sv @@
// Shared types, constants and the CRC32 byte update for the section deframer.
// No dependencies; used by the top level and its checker.
`default_nettype none

package ssdc_pkg;

   localparam int HDR_LEN = 5;

   localparam logic [7:0]  SYNC_B0       = 8'h60;
   localparam logic [7:0]  SYNC_B1       = 8'h00;
   localparam logic [7:0]  SYNC_B2       = 8'h00;
   localparam logic [7:0]  SYNC_B3       = 8'hB0;
   localparam logic [12:0] MAX_BYTES_RST = 13'd4100;
   localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

   typedef enum logic {
      PH_HEADER,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY,
      ST_CRC_OK,
      ST_CRC_ERR,
      ST_ZERO_LEN,
      ST_TOO_LONG
   } status_type;

   typedef logic [7:0] byte_type;

   // Expected byte at each hunt position (0 to 3).
   function automatic byte_type sync_byte(input logic [1:0] pos);
      byte_type b;
      unique case (pos)
         2'd0: b = SYNC_B0;
         2'd1: b = SYNC_B1;
         2'd2: b = SYNC_B2;
         2'd3: b = SYNC_B3;
         default: b = SYNC_B0;
      endcase
      return b;
   endfunction

   // MSB-first CRC32 update by one byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input byte_type b);
      logic [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/section_sync_deframer_crc_check.sv @@
// Section deframer with registered results; body bytes at 1 per cycle unless the output stalls.
// A good header gives 5 results from one byte, so the input stalls after each header
// while the result register drains the held header; earlier header bytes give no result.
// Sync hunt, phase, header position, length count and output valid clear on reset;
// max_section_bytes resets to 4100. Depends on ssdc_pkg.
`default_nettype none

module section_sync_deframer_crc_check (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [12:0] csr_wr_data,   // max_section_bytes
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,     // data_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,     // out_byte [7:0], pid [20:8], zero fill
   output logic [3:0]  rsp_tuser,     // section_start [0], status [3:1]
   output logic        rsp_tlast      // section_last
);

   // control state
   logic                 in_sync_ff, in_sync_in;
   ssdc_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           hpos_ff, hpos_in;
   logic [11:0]          remain_ff, remain_in;
   logic [31:0]          crc_ff, crc_in;
   logic [2:0]           hdr_left_ff, hdr_left_in;
   logic [12:0]          max_bytes_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   ssdc_pkg::byte_type   hdr_ff [ssdc_pkg::HDR_LEN];
   ssdc_pkg::byte_type   hdr_in [ssdc_pkg::HDR_LEN];
   logic [7:0]           byte_ff, byte_in;
   logic [12:0]          pid_ff, pid_in;
   logic                 start_ff, start_in;
   logic                 last_ff, last_in;
   ssdc_pkg::status_type status_ff, status_in;

   logic        accept;
   logic        out_free;
   logic [2:0]  pos;
   logic [2:0]  hdr_idx;
   logic [31:0] crc_step;
   logic [11:0] len;
   logic [12:0] total;
   logic [12:0] pid_now;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (hdr_left_ff == 3'd0) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, pid_ff, byte_ff};
   assign rsp_tuser  = {status_ff, start_ff};
   assign rsp_tlast  = last_ff;

   always_comb begin
      in_sync_in   = in_sync_ff;
      phase_in     = phase_ff;
      hpos_in      = hpos_ff;
      remain_in    = remain_ff;
      crc_in       = crc_ff;
      hdr_left_in  = hdr_left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hdr_in       = hdr_ff;
      byte_in      = byte_ff;
      pid_in       = pid_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      status_in    = status_ff;

      pos      = (hpos_ff >= 3'(ssdc_pkg::HDR_LEN)) ? 3'd0 : hpos_ff;
      hdr_idx  = 3'(ssdc_pkg::HDR_LEN) - hdr_left_ff;
      pid_now  = {hdr_ff[0][4:0], hdr_ff[1]};
      len      = {hdr_ff[3][3:0], req_tdata};
      total    = 13'(ssdc_pkg::HDR_LEN) + {1'b0, len};
      // header CRC starts afresh at byte 2
      crc_step = ssdc_pkg::crc_byte(
         (phase_ff == ssdc_pkg::PH_HEADER && pos == 3'd2) ? ssdc_pkg::CRC_INIT : crc_ff,
         req_tdata);

      if (hdr_left_ff != 3'd0) begin
         // drain the held header bytes one transfer at a time
         if (out_free) begin
            rsp_valid_in = 1'b1;
            byte_in      = hdr_ff[hdr_idx];
            pid_in       = pid_now;
            start_in     = 1'b0;
            last_in      = 1'b0;
            status_in    = ssdc_pkg::ST_BUSY;
            hdr_left_in  = hdr_left_ff - 3'd1;
         end
      end else if (accept) begin
         unique case (phase_ff)
            ssdc_pkg::PH_BODY: begin
               crc_in       = crc_step;
               remain_in    = remain_ff - 12'd1;
               rsp_valid_in = 1'b1;
               byte_in      = req_tdata;
               pid_in       = pid_now;
               start_in     = 1'b0;
               if (remain_in == 12'd0) begin
                  last_in    = 1'b1;
                  status_in  = (crc_step == 32'd0) ? ssdc_pkg::ST_CRC_OK
                                                   : ssdc_pkg::ST_CRC_ERR;
                  in_sync_in = 1'b1;
                  phase_in   = ssdc_pkg::PH_HEADER;
                  hpos_in    = 3'd0;
               end else begin
                  last_in   = 1'b0;
                  status_in = ssdc_pkg::ST_BUSY;
               end
            end
            ssdc_pkg::PH_HEADER: begin
               if (!in_sync_ff && pos < 3'd4
                   && req_tdata != ssdc_pkg::sync_byte(pos[1:0])) begin
                  // restart the hunt, keeping a fresh first byte
                  if (req_tdata == ssdc_pkg::SYNC_B0) begin
                     hdr_in[0] = req_tdata;
                     hpos_in   = 3'd1;
                  end else begin
                     hpos_in = 3'd0;
                  end
               end else begin
                  hdr_in[pos] = req_tdata;
                  if (pos >= 3'd2) begin
                     crc_in = crc_step;
                  end
                  if (pos != 3'd4) begin
                     hpos_in = pos + 3'd1;
                  end else begin
                     hpos_in      = 3'd0;
                     rsp_valid_in = 1'b1;
                     pid_in       = pid_now;
                     priority if (len == 12'd0) begin
                        in_sync_in = 1'b0;
                        byte_in    = 8'd0;
                        start_in   = 1'b0;
                        last_in    = 1'b1;
                        status_in  = ssdc_pkg::ST_ZERO_LEN;
                     end else if (total > max_bytes_ff) begin
                        in_sync_in = 1'b0;
                        byte_in    = 8'd0;
                        start_in   = 1'b0;
                        last_in    = 1'b1;
                        status_in  = ssdc_pkg::ST_TOO_LONG;
                     end else begin
                        remain_in   = len;
                        phase_in    = ssdc_pkg::PH_BODY;
                        byte_in     = {3'b000, hdr_ff[0][4:0]};
                        start_in    = 1'b1;
                        last_in     = 1'b0;
                        status_in   = ssdc_pkg::ST_BUSY;
                        hdr_left_in = 3'(ssdc_pkg::HDR_LEN - 1);
                     end
                  end
               end
            end
            default: phase_in = ssdc_pkg::PH_HEADER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sync_ff   <= 1'b0;
         phase_ff     <= ssdc_pkg::PH_HEADER;
         hpos_ff      <= 3'd0;
         remain_ff    <= 12'd0;
         crc_ff       <= ssdc_pkg::CRC_INIT;
         hdr_left_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
         max_bytes_ff <= ssdc_pkg::MAX_BYTES_RST;
      end else begin
         in_sync_ff   <= in_sync_in;
         phase_ff     <= phase_in;
         hpos_ff      <= hpos_in;
         remain_ff    <= remain_in;
         crc_ff       <= crc_in;
         hdr_left_ff  <= hdr_left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_bytes_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff    <= hdr_in;
      byte_ff   <= byte_in;
      pid_ff    <= pid_in;
      start_ff  <= start_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

@@ hdl/ssdc_checker.sv @@
// Port-level checks for the section deframer, bound to the top level.
// Depends on ssdc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ssdc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [3:0]  rsp_tuser,
   input wire        rsp_tlast
);

   // hold a stalled result
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // a final status comes exactly with the end of a section or an error
   `CHK_SAME(a_last_status, clock, reset, rsp_tvalid,
      rsp_tlast == (rsp_tuser[3:1] != ssdc_pkg::ST_BUSY)
      && rsp_tuser[3:1] <= ssdc_pkg::ST_TOO_LONG)

   // a section start is never also a final result
   `CHK_SAME(a_start_busy, clock, reset, rsp_tvalid && rsp_tuser[0],
      !rsp_tlast && rsp_tuser[3:1] == ssdc_pkg::ST_BUSY)

   // the rest of the header is still queued once the start transfer is taken
   `CHK_NEXT(a_hdr_stall, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser[0],
      !req_tready && rsp_tvalid)

endmodule

bind section_sync_deframer_crc_check ssdc_checker u_ssdc_checker (.*);

`default_nettype wire
